/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int ALIGNMENT      = 8;
    localparam int HDR_GRANULES   = 3;
    localparam int MIN_GRANULES   = 5;

    localparam int FM_SIZE  = 0;
    localparam int FM_ALLOC = 1;
    localparam int FM_NEXT  = 2;
    localparam int FM_PREV  = 3;

    typedef enum logic {
        K_ALLOC = 1'b0,
        K_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_MEMORY = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [16:0] request_bytes;
        logic [15:0] release_offset;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] payload_offset;
    } t_out_item;

    typedef struct packed {
        logic       we;
        logic [3:0] mask;
        logic       re;
    } t_ram_ctl;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_A_UNP,
        S_A_UNN,
        S_A_REM,
        S_A_OLDH,
        S_A_FIN,
        S_F_CHK,
        S_F_PUSH,
        S_F_OLDH,
        S_F_NRD,
        S_F_NCHK,
        S_F_NUNP,
        S_F_NUNN,
        S_F_NSZ,
        S_F_WST,
        S_F_WCHK,
        S_F_GUNP,
        S_F_GUNN,
        S_F_CSZ,
        S_DONE
    } t_state;

endpackage

/* hdl/ffha_hdr_ram.sv */
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Block header memory with per-field write enables and a registered read.
// ----------------------------------------------------------------------------
module ffha_hdr_ram
    import ffha_pkg::*;
#(
    parameter int GW = 13,
    parameter int HW = 3 * GW + 4
) (
    input  logic          i_clk,
    input  t_ram_ctl      i_ctl,
    input  logic [GW-1:0] i_waddr,
    input  logic [HW-1:0] i_wdata,
    input  logic [GW-1:0] i_raddr,
    output logic [HW-1:0] o_rdata
);

    logic [HW-1:0] mem [2**GW];
    logic [HW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            if (i_ctl.mask[FM_SIZE]) begin
                mem[i_waddr][3*GW+3:2*GW+3] <= i_wdata[3*GW+3:2*GW+3];
            end
            if (i_ctl.mask[FM_ALLOC]) begin
                mem[i_waddr][2*GW+2] <= i_wdata[2*GW+2];
            end
            if (i_ctl.mask[FM_NEXT]) begin
                mem[i_waddr][2*GW+1:GW+1] <= i_wdata[2*GW+1:GW+1];
            end
            if (i_ctl.mask[FM_PREV]) begin
                mem[i_waddr][GW:0] <= i_wdata[GW:0];
            end
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks the free list and edits block headers in memory.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF,
    parameter int GW = $clog2(HEAP_BYTES / ALIGNMENT),
    parameter int HW = 3 * GW + 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in_item,
    output logic          o_done,
    output t_out_item     o_res,
    input  logic          i_slot_free,
    output t_ram_ctl      o_ram,
    output logic [GW-1:0] o_waddr,
    output logic [HW-1:0] o_wdata,
    output logic [GW-1:0] o_raddr,
    input  logic [HW-1:0] i_rdata
);

    localparam int GRAN = HEAP_BYTES / ALIGNMENT;
    localparam int CW   = (GW + 2 > 16) ? GW + 2 : 16;
    localparam logic [CW-1:0] GRAN_C = CW'(GRAN);

    typedef struct packed {
        logic [GW:0]   size;
        logic          alloc;
        logic [GW-1:0] next;
        logic          hn;
        logic [GW-1:0] prev;
        logic          hp;
    } t_hdr;

    t_state        r_state, n_state;
    logic [GW-1:0] r_head, n_head;
    logic          r_hvalid, n_hvalid;
    logic [CW-1:0] r_total, n_total;
    logic [GW-1:0] r_cur, n_cur;
    t_hdr          r_hdr, n_hdr;
    logic [GW-1:0] r_g, n_g;
    logic [CW-1:0] r_gsize, n_gsize;
    logic [GW-1:0] r_gnext, n_gnext;
    logic          r_ghn, n_ghn;
    t_status       r_status, n_status;
    logic [15:0]   r_off, n_off;

    t_hdr          h;
    t_hdr          w;
    logic          accept;
    logic [17:0]   req_up;
    logic [14:0]   req_g;
    logic [15:0]   tot;
    logic [15:0]   off_m;
    logic [CW-1:0] g_ext;
    logic          f_bad;
    logic          hit;
    logic          split;
    logic [GW-1:0] rem;
    logic [CW-1:0] nx;
    logic          adj;
    logic [CW+3:0] off_full;

    assign h      = t_hdr'(i_rdata);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        req_up = {1'b0, i_in_item.request_bytes} + 18'd7;
        req_g  = (i_in_item.request_bytes == '0) ? 15'd1 : req_up[17:3];
        tot    = {1'b0, req_g} + 16'(HDR_GRANULES);
        if (tot < 16'(MIN_GRANULES)) begin
            tot = 16'(MIN_GRANULES);
        end
        off_m = i_in_item.release_offset - 16'd24;
        g_ext = CW'(off_m[15:3]);
        f_bad = (i_in_item.release_offset < 16'd24) ||
                (i_in_item.release_offset[2:0] != 3'd0) || (g_ext >= GRAN_C);
        hit   = CW'(h.size) >= r_total;
        split = CW'(r_hdr.size) >= r_total + CW'(MIN_GRANULES);
        rem   = r_cur + r_total[GW-1:0];
        nx    = CW'(r_g) + r_gsize;
        adj   = CW'(r_cur) + CW'(h.size) == CW'(r_g);
        off_full = {CW'(r_cur), 3'b000} + (CW + 4)'(24);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_in_item.kind == K_ALLOC) begin
                        n_state = r_hvalid ? S_A_CHK : S_DONE;
                    end else begin
                        n_state = f_bad ? S_DONE : S_F_CHK;
                    end
                end
            end
            S_A_CHK: begin
                if (hit) begin
                    n_state = S_A_UNP;
                end else if (!h.hn) begin
                    n_state = S_DONE;
                end
            end
            S_A_UNP:  n_state = S_A_UNN;
            S_A_UNN:  n_state = split ? S_A_REM : S_A_FIN;
            S_A_REM:  n_state = S_A_OLDH;
            S_A_OLDH: n_state = S_A_FIN;
            S_A_FIN:  n_state = S_DONE;
            S_F_CHK:  n_state = h.alloc ? S_F_PUSH : S_DONE;
            S_F_PUSH: n_state = S_F_OLDH;
            S_F_OLDH: n_state = (nx < GRAN_C) ? S_F_NRD : S_F_WST;
            S_F_NRD:  n_state = S_F_NCHK;
            S_F_NCHK: n_state = h.alloc ? S_F_WST : S_F_NUNP;
            S_F_NUNP: n_state = S_F_NUNN;
            S_F_NUNN: n_state = S_F_NSZ;
            S_F_NSZ:  n_state = S_F_WST;
            S_F_WST:  n_state = (r_g != '0 && r_hvalid) ? S_F_WCHK : S_DONE;
            S_F_WCHK: begin
                if (adj) begin
                    n_state = S_F_GUNP;
                end else if (!h.hn) begin
                    n_state = S_DONE;
                end
            end
            S_F_GUNP: n_state = S_F_GUNN;
            S_F_GUNN: n_state = S_F_CSZ;
            S_F_CSZ:  n_state = S_DONE;
            S_DONE:   n_state = i_slot_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_hvalid = r_hvalid;
        n_total  = r_total;
        n_cur    = r_cur;
        n_hdr    = r_hdr;
        n_g      = r_g;
        n_gsize  = r_gsize;
        n_gnext  = r_gnext;
        n_ghn    = r_ghn;
        n_status = r_status;
        n_off    = r_off;
        o_ram    = '0;
        o_waddr  = '0;
        o_raddr  = '0;
        w        = '0;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_ram.we   = 1'b1;
                o_ram.mask = 4'b1111;
                w.size     = (GW + 1)'(GRAN);
                n_head     = '0;
                n_hvalid   = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_off = '0;
                    if (i_in_item.kind == K_ALLOC) begin
                        n_total  = CW'(tot);
                        n_status = ST_NO_MEMORY;
                        o_ram.re = r_hvalid;
                        o_raddr  = r_head;
                        n_cur    = r_head;
                    end else begin
                        n_status = ST_IGNORED;
                        n_g      = g_ext[GW-1:0];
                        o_ram.re = !f_bad;
                        o_raddr  = g_ext[GW-1:0];
                    end
                end
            end
            S_A_CHK: begin
                if (hit) begin
                    n_hdr = h;
                end else if (h.hn) begin
                    o_ram.re = 1'b1;
                    o_raddr  = h.next;
                    n_cur    = h.next;
                end
            end
            S_A_UNP, S_F_NUNP: begin
                if (r_hdr.hp) begin
                    o_ram.we   = 1'b1;
                    o_ram.mask[FM_NEXT] = 1'b1;
                    o_waddr    = r_hdr.prev;
                    w.next     = r_hdr.next;
                    w.hn       = r_hdr.hn;
                    if (r_state == S_F_NUNP && r_hdr.prev == r_g) begin
                        n_gnext = r_hdr.next;
                        n_ghn   = r_hdr.hn;
                    end
                end else begin
                    n_head   = r_hdr.next;
                    n_hvalid = r_hdr.hn;
                end
            end
            S_A_UNN, S_F_NUNN: begin
                o_ram.we = r_hdr.hn;
                o_ram.mask[FM_PREV] = 1'b1;
                o_waddr  = r_hdr.next;
                w.prev   = r_hdr.prev;
                w.hp     = r_hdr.hp;
                if (r_state == S_F_NUNN) begin
                    n_gsize = r_gsize + CW'(r_hdr.size);
                end
            end
            S_A_REM: begin
                o_ram.we   = 1'b1;
                o_ram.mask = 4'b1111;
                o_waddr    = rem;
                w.size     = r_hdr.size - r_total[GW:0];
                w.next     = r_head;
                w.hn       = r_hvalid;
            end
            S_A_OLDH: begin
                o_ram.we = r_hvalid;
                o_ram.mask[FM_PREV] = 1'b1;
                o_waddr  = r_head;
                w.prev   = rem;
                w.hp     = 1'b1;
                n_head   = rem;
                n_hvalid = 1'b1;
                n_hdr.size = r_total[GW:0];
            end
            S_A_FIN: begin
                o_ram.we = 1'b1;
                o_ram.mask[FM_SIZE]  = 1'b1;
                o_ram.mask[FM_ALLOC] = 1'b1;
                o_waddr  = r_cur;
                w.size   = r_hdr.size;
                w.alloc  = 1'b1;
                n_status = ST_ALLOCATED;
                n_off    = off_full[15:0];
            end
            S_F_CHK: begin
                n_gsize = CW'(h.size);
            end
            S_F_PUSH: begin
                o_ram.we = 1'b1;
                o_ram.mask[FM_ALLOC] = 1'b1;
                o_ram.mask[FM_NEXT]  = 1'b1;
                o_ram.mask[FM_PREV]  = 1'b1;
                o_waddr  = r_g;
                w.next   = r_head;
                w.hn     = r_hvalid;
                n_gnext  = r_head;
                n_ghn    = r_hvalid;
                n_status = ST_FREED;
            end
            S_F_OLDH: begin
                o_ram.we = r_hvalid;
                o_ram.mask[FM_PREV] = 1'b1;
                o_waddr  = r_head;
                w.prev   = r_g;
                w.hp     = 1'b1;
                n_head   = r_g;
                n_hvalid = 1'b1;
            end
            S_F_NRD: begin
                o_ram.re = 1'b1;
                o_raddr  = nx[GW-1:0];
            end
            S_F_NCHK: begin
                n_hdr = h;
            end
            S_F_NSZ: begin
                o_ram.we = 1'b1;
                o_ram.mask[FM_SIZE] = 1'b1;
                o_waddr  = r_g;
                w.size   = r_gsize[GW:0];
            end
            S_F_WST: begin
                o_ram.re = r_g != '0 && r_hvalid;
                o_raddr  = r_head;
                n_cur    = r_head;
            end
            S_F_WCHK: begin
                if (adj) begin
                    n_hdr = h;
                end else if (h.hn) begin
                    o_ram.re = 1'b1;
                    o_raddr  = h.next;
                    n_cur    = h.next;
                end
            end
            S_F_GUNP: begin
                n_head   = r_gnext;
                n_hvalid = r_ghn;
            end
            S_F_GUNN: begin
                o_ram.we = r_ghn;
                o_ram.mask[FM_PREV] = 1'b1;
                o_waddr  = r_gnext;
            end
            S_F_CSZ: begin
                o_ram.we = 1'b1;
                o_ram.mask[FM_SIZE] = 1'b1;
                o_waddr  = r_cur;
                w.size   = r_hdr.size + r_gsize[GW:0];
            end
            S_DONE: begin
                o_done = i_slot_free;
            end
            default: begin
            end
        endcase
    end

    assign o_wdata = HW'(w);
    assign o_res   = '{status: r_status, payload_offset: r_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_head   <= '0;
            r_hvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_hvalid <= n_hvalid;
        end
        r_total  <= n_total;
        r_cur    <= n_cur;
        r_hdr    <= n_hdr;
        r_g      <= n_g;
        r_gsize  <= n_gsize;
        r_gnext  <= n_gnext;
        r_ghn    <= n_ghn;
        r_status <= n_status;
        r_off    <= n_off;
    end

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram.we && o_ram.re && o_waddr == o_raddr))
        else $error("header read and write hit the same entry");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted item did not start work");

    a_done_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_DONE && i_slot_free)
        else $error("result issued outside the done state");

endmodule

/* hdl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Explicit free-list first-fit allocator over a tiled byte heap.
// ----------------------------------------------------------------------------
// An allocate inspects free-list headers in order until one fits, then
// unlinks it, splits off a remainder when large enough, and marks it allocated.
// A free rejects a bad offset, ignores a header not allocated, else pushes
// the block on the list, merges a free next block and then walks the list
// to merge into a preceding block; one memory.
// One item is in work at a time; a finished result waits in an output register.
// After reset, the init state writes the initial free block before input is taken.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int GW = $clog2(HEAP_BYTES / ALIGNMENT);
    localparam int HW = 3 * GW + 4;

    t_ram_ctl      ram_ctl;
    logic [GW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic [GW-1:0] raddr;
    logic [HW-1:0] rdata;
    logic          done;
    t_out_item     res;
    logic          slot_free;
    logic          r_valid;
    t_out_item     r_item;

    assign slot_free = !r_valid || i_out_ready;

    ffha_ctrl #(
        .HEAP_BYTES(HEAP_BYTES),
        .GW(GW),
        .HW(HW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_done(done),
        .o_res(res),
        .i_slot_free(slot_free),
        .o_ram(ram_ctl),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_raddr(raddr),
        .i_rdata(rdata)
    );

    ffha_hdr_ram #(
        .GW(GW),
        .HW(HW)
    ) u_ram (
        .i_clk(i_clk),
        .i_ctl(ram_ctl),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (done) begin
            r_item <= res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_done_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_valid || i_out_ready))
        else $error("result overwrote an item not yet taken");

endmodule

/* test/tb_first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking testbench for the first-fit heap allocator.
// A behavioral heap model predicts every result. The stimulus is directed
// items followed by random allocate and free traffic, with random stalls on
// both handshakes.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRAN      = HEAP_BYTES_DEF / ALIGNMENT;
    localparam int HDR_B     = HDR_GRANULES * ALIGNMENT;
    localparam int MIN_B     = MIN_GRANULES * ALIGNMENT;
    localparam int N_RANDOM  = 1130;
    localparam int MAX_CYC   = 4000000;

    class heap_scoreboard;
        int unsigned blk_sz[GRAN];
        bit          blk_used[GRAN];
        int unsigned lnk_next[GRAN];
        int unsigned lnk_prev[GRAN];
        bit          has_next[GRAN];
        bit          has_prev[GRAN];
        bit          hdr_written[GRAN];
        int unsigned free_head;
        bit          head_ok;
        int unsigned hdr_list[$];
        int unsigned live[$];
        t_out_item   pending[$];
        int          errors;
        int          n_status[4];

        function new();
            blk_sz[0] = HEAP_BYTES_DEF;
            hdr_written[0] = 1;
            hdr_list.push_back(0);
            free_head = 0;
            head_ok = 1;
        endfunction

        function void unlink(int unsigned g);
            int unsigned p;
            int unsigned n;
            p = lnk_prev[g];
            n = lnk_next[g];
            if (has_prev[g] && p < GRAN) begin
                lnk_next[p] = n;
                has_next[p] = has_next[g];
            end else begin
                free_head = n;
                head_ok = has_next[g];
            end
            if (has_next[g] && n < GRAN) begin
                lnk_prev[n] = p;
                has_prev[n] = has_prev[g];
            end
            has_next[g] = 0;
            has_prev[g] = 0;
            lnk_next[g] = 0;
            lnk_prev[g] = 0;
        endfunction

        function void push_front(int unsigned g);
            lnk_next[g] = free_head;
            has_next[g] = head_ok;
            lnk_prev[g] = 0;
            has_prev[g] = 0;
            if (head_ok && free_head < GRAN) begin
                lnk_prev[free_head] = g;
                has_prev[free_head] = 1;
            end
            free_head = g;
            head_ok = 1;
        endfunction

        function t_out_item predict_alloc(int unsigned req);
            t_out_item   r;
            int unsigned total;
            int unsigned cur;
            int unsigned rem;
            int unsigned found;
            bit          have;
            bit          hit;
            r = '{ST_NO_MEMORY, 16'd0};
            hit = 0;
            found = 0;
            if (req == 0) req = ALIGNMENT;
            req = (req + ALIGNMENT - 1) & ~(ALIGNMENT - 1);
            total = req + HDR_B;
            if (total < MIN_B) total = MIN_B;
            cur = free_head;
            have = head_ok;
            for (int s = 0; have && cur < GRAN && s < GRAN; s++) begin
                if (blk_sz[cur] >= total) begin
                    found = cur;
                    hit = 1;
                    break;
                end
                have = has_next[cur];
                cur = lnk_next[cur];
            end
            if (!hit) return r;
            unlink(found);
            if (blk_sz[found] >= total + MIN_B) begin
                rem = found + total / ALIGNMENT;
                if (rem < GRAN) begin
                    blk_sz[rem] = blk_sz[found] - total;
                    blk_used[rem] = 0;
                    if (!hdr_written[rem]) begin
                        hdr_written[rem] = 1;
                        hdr_list.push_back(rem);
                    end
                    push_front(rem);
                    blk_sz[found] = total;
                end
            end
            blk_used[found] = 1;
            r.status = ST_ALLOCATED;
            r.payload_offset = 16'(found * ALIGNMENT + HDR_B);
            return r;
        endfunction

        function t_out_item predict_free(int unsigned off);
            t_out_item   r;
            int unsigned g;
            int unsigned nx;
            int unsigned cur;
            bit          have;
            r = '{ST_IGNORED, 16'd0};
            if (off < HDR_B || off % ALIGNMENT != 0) return r;
            g = (off - HDR_B) / ALIGNMENT;
            if (g >= GRAN || !blk_used[g]) return r;
            blk_used[g] = 0;
            push_front(g);
            nx = g + blk_sz[g] / ALIGNMENT;
            if (nx > g && nx < GRAN && !blk_used[nx]) begin
                unlink(nx);
                blk_sz[g] += blk_sz[nx];
            end
            if (g > 0) begin
                cur = free_head;
                have = head_ok;
                for (int s = 0; have && cur < GRAN && s < GRAN; s++) begin
                    if (cur + blk_sz[cur] / ALIGNMENT == g) begin
                        unlink(g);
                        blk_sz[cur] += blk_sz[g];
                        break;
                    end
                    have = has_next[cur];
                    cur = lnk_next[cur];
                end
            end
            r.status = ST_FREED;
            return r;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            if (it.kind == K_ALLOC) begin
                r = predict_alloc(it.request_bytes);
                if (r.status == ST_ALLOCATED) live.push_back(r.payload_offset);
            end else begin
                r = predict_free(it.release_offset);
                if (r.status == ST_FREED)
                    foreach (live[i])
                        if (live[i] == it.release_offset) begin
                            live.delete(i);
                            break;
                        end
            end
            n_status[r.status]++;
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d", $time,
                         got.status, got.payload_offset);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
            if (got.payload_offset !== want.payload_offset) begin
                $display("%0t: payload_offset expected %0d actual %0d", $time,
                         want.payload_offset, got.payload_offset);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    heap_scoreboard sb = new();
    bit  no_idle;
    int  results_seen;
    int  cycles;

    first_fit_heap_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("first_fit_heap_allocator: mismatch");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
            results_seen <= results_seen + 1;
        end
    end

    initial begin
        int  gap;
        bit  held;
        held = 0;
        i_out_ready = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (!held && results_seen >= 300) begin
                held = 1;
                gap = 600;
            end
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_input(it);
    endtask

    task automatic send_alloc(int unsigned req);
        send_item('{K_ALLOC, 17'(req), 16'($urandom)});
    endtask

    task automatic send_free(int unsigned off);
        send_item('{K_FREE, 17'($urandom), 16'(off)});
    endtask

    task automatic drain();
        i_in_valid <= 0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic int unsigned noise_offset();
        int unsigned o;
        if ($urandom_range(0, 1)) return $urandom_range(0, HDR_B - 1);
        o = $urandom_range(0, 65535);
        if (o % ALIGNMENT == 0) o = o | $urandom_range(1, ALIGNMENT - 1);
        return o;
    endfunction

    function automatic int unsigned alloc_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(0, 256);
        if (p < 90) return $urandom_range(0, 4096);
        if (p < 97) return $urandom_range(0, 65536);
        return $urandom_range(0, 131071);
    endfunction

    initial begin
        int unsigned keep;
        int unsigned p;
        int unsigned g;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        no_idle = 0;
        results_seen = 0;
        cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_alloc(0);
        send_alloc(1);
        send_alloc(8);
        send_alloc(100);
        send_alloc(65536);
        send_alloc(131071);
        send_free(0);
        send_free(HDR_B - 4);
        send_free(HDR_B + 1);
        send_free(65535);
        drain();
        keep = sb.live[1];
        send_free(keep);
        send_free(keep);
        send_free(sb.hdr_list[sb.hdr_list.size() - 1] * ALIGNMENT + HDR_B);
        while (sb.live.size() > 0) begin
            drain();
            send_free(sb.live[0]);
        end
        send_alloc(HEAP_BYTES_DEF - HDR_B);
        drain();
        send_free(sb.live[0]);
        send_alloc(HEAP_BYTES_DEF - HDR_B + 1);

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 700 && n < 800);
            if (n == 500) drain();
            p = $urandom_range(0, 99);
            if (sb.live.size() > 120) p = p / 2 + 50;
            if (p < 50) begin
                send_alloc(alloc_size());
            end else if (p < 85 && sb.live.size() > 0) begin
                send_free(sb.live[$urandom_range(0, sb.live.size() - 1)]);
            end else if (p < 93) begin
                g = sb.hdr_list[$urandom_range(0, sb.hdr_list.size() - 1)];
                send_free(g * ALIGNMENT + HDR_B);
            end else begin
                send_free(noise_offset());
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d allocations, %0d out-of-memory, %0d frees, %0d ignored frees.",
                 sb.n_status[ST_ALLOCATED], sb.n_status[ST_NO_MEMORY],
                 sb.n_status[ST_FREED], sb.n_status[ST_IGNORED]);
        $display("Traffic ran with random stalls, a long output hold and a drain pause.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("first_fit_heap_allocator: match");
        end else begin
            $display("first_fit_heap_allocator: mismatch");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/ffha_pkg.sv
hdl/ffha_hdr_ram.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator.sv
test/tb_first_fit_heap_allocator.sv
